// File: src/cdsd_pkg.sv
package cdsd_pkg;

    // pipeline depth inside the datapath modules (the output register sits in the top level)
    localparam int C_STAGES = 4;

    typedef logic [C_STAGES-1:0] t_stage_en;

    localparam logic [26:0] C_MS_PER_DAY  = 27'd86400000;
    localparam logic [26:0] C_MS_PER_HOUR = 27'd3600000;
    localparam logic [26:0] C_MS_PER_MIN  = 27'd60000;

    // low bits of the correction remainder: true remainder stays below three days of ms
    localparam int C_REM_W = 29;
    localparam logic [C_REM_W-1:0] C_REM_ONE   = C_REM_W'(C_MS_PER_DAY);
    localparam logic [C_REM_W-1:0] C_REM_TWO   = C_REM_W'(2 * 86400000);
    localparam logic [C_REM_W-1:0] C_REM_LIMIT = C_REM_W'(3 * 86400000);

    // floor(2^58 / ms per day), fits 32 bits; quotient estimate is (ms * recip) >> 26
    localparam logic [63:0] C_FRAC_RECIP_W = 64'h0400_0000_0000_0000 / 64'd86400000;
    localparam logic [31:0] C_FRAC_RECIP   = C_FRAC_RECIP_W[31:0];
    localparam int C_FRAC_SHIFT = 26;

    localparam int C_DAYS_W = 25;
    localparam logic signed [C_DAYS_W-1:0] C_DAYS_MAX = 25'sd4194303;
    localparam logic signed [C_DAYS_W-1:0] C_LEAP_BUG_DAY = 25'sd59;

endpackage

// File: src/calendar_date_to_serial_day_top.sv
// calendar date and time of day to spreadsheet serial date
//
// input word on s_axis: year, month, day, hour, minute and seconds in ms;
// output word on m_axis: signed whole day count and the fraction of the day
// as unsigned q0.32, truncated. i_cfg_we writes i_cfg_wdata into the epoch
// bit (0 = 1900 epoch with its leap-day bug, 1 = 1904 epoch); write it only
// while no word is in flight.
//
// throughput: one word per cycle while m_axis does not stall; a word passes
// through four datapath stages and then the output register, each with its
// own valid bit. The fraction path sets the depth: time sum, day carry,
// reciprocal multiply, back-multiply, correction.
//
// a stage loads whenever it is empty or the next one moves, so bubbles close
// up and the block keeps taking words while a result waits on m_axis. A stall
// of m_axis fills the pipe and then drops s_axis_tready; nothing is lost or
// repeated. Reset clears all valid bits and the epoch bit.
module calendar_date_to_serial_day_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] second_ms[49:34]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // serial_days[22:0] day_fraction[54:23]
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);
    import cdsd_pkg::*;

    localparam int C_DEPTH = C_STAGES + 1;

    logic               r_epoch_1904;
    logic [C_DEPTH-1:0] r_vld;
    logic [C_DEPTH-1:0] n_vld;
    logic [C_DEPTH-1:0] w_rdy;
    t_stage_en          w_en;

    logic               w_carry;
    logic [31:0]        w_qest;
    logic [C_REM_W-1:0] w_prod_lo;
    logic [C_REM_W-1:0] w_rem;
    logic signed [C_DAYS_W-1:0] w_days;
    logic               w_no_bump;
    logic               w_bump;
    logic signed [C_DAYS_W-1:0] w_sum;
    logic               w_sat;
    logic [31:0]        w_frac;

    logic [22:0]        r_serial;
    logic [31:0]        r_frac;

    // ready runs back from the output: a stage may load if empty or draining
    always_comb begin
        w_rdy[C_DEPTH-1] = !r_vld[C_DEPTH-1] || m_axis_tready;
        for (int k = C_DEPTH - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        if (w_rdy[0]) begin
            n_vld[0] = s_axis_tvalid;
        end else begin
            n_vld[0] = r_vld[0];
        end
        for (int k = 1; k < C_DEPTH; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    assign w_en = w_rdy[C_STAGES-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_epoch_1904 <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_epoch_1904 <= i_cfg_wdata;
            end
        end
    end

    // fraction of the day and the whole-day carry of the time fields
    cdsd_time u_time (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_hour      (s_axis_tdata[27:23]),
        .i_minute    (s_axis_tdata[33:28]),
        .i_second_ms (s_axis_tdata[49:34]),
        .o_carry     (w_carry),
        .o_qest      (w_qest),
        .o_prod_lo   (w_prod_lo)
    );

    // day count of the date fields
    cdsd_date u_date (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_year       (s_axis_tdata[13:0]),
        .i_month      (s_axis_tdata[17:14]),
        .i_day        (s_axis_tdata[22:18]),
        .i_epoch_1904 (r_epoch_1904),
        .o_days       (w_days),
        .o_no_bump    (w_no_bump)
    );

    // remainder of ms * 2^32 over ms per day; the ms * 2^32 term vanishes in the low bits
    assign w_rem  = C_REM_W'(0) - w_prod_lo;
    assign w_frac = w_qest + 32'(w_rem >= C_REM_ONE) + 32'(w_rem >= C_REM_TWO);

    // 1900 epoch counts the false feb 29, so later days move up by one
    assign w_bump = !w_no_bump && (w_days > C_LEAP_BUG_DAY);
    assign w_sum  = w_days + C_DAYS_W'(w_bump) + C_DAYS_W'(w_carry);
    assign w_sat  = (w_sum > C_DAYS_MAX);

    // output register
    always_ff @(posedge i_clk) begin
        if (w_rdy[C_DEPTH-1]) begin
            r_serial <= w_sat ? C_DAYS_MAX[22:0] : w_sum[22:0];
            r_frac   <= w_sat ? 32'hFFFF_FFFF : w_frac;
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[C_DEPTH-1];
    assign m_axis_tdata  = {1'b0, r_frac, r_serial};

    // an accepted word always lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted word not captured in first stage");

    // a full pipe behind a stalled output must not take a word
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !m_axis_tready) |-> !s_axis_tready)
        else $error("word accepted into a full stalled pipe");

    // a word moves into an empty next stage
    a_bubble_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !r_vld[2]) |=> r_vld[2])
        else $error("word did not advance into empty stage");

    // reciprocal estimate is never more than two low
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[C_STAGES-1] |-> (w_rem < C_REM_LIMIT))
        else $error("fraction correction out of range");

endmodule

// File: src/cdsd_time.sv
module cdsd_time (
    input  logic                 i_clk,
    input  cdsd_pkg::t_stage_en  i_en,
    input  logic [4:0]           i_hour,
    input  logic [5:0]           i_minute,
    input  logic [15:0]          i_second_ms,
    output logic                 o_carry,
    output logic [31:0]          o_qest,
    output logic [cdsd_pkg::C_REM_W-1:0] o_prod_lo
);
    import cdsd_pkg::*;

    logic [26:0]        r_ms1;
    logic               r_carry2;
    logic [26:0]        r_msm2;
    logic               r_carry3;
    logic [31:0]        r_qest3;
    logic               r_carry4;
    logic [31:0]        r_qest4;
    logic [C_REM_W-1:0] r_prod4;

    logic               w_carry;
    logic [58:0]        w_prod;

    assign w_carry = (r_ms1 >= C_MS_PER_DAY);
    assign w_prod  = 59'(r_msm2) * 59'(C_FRAC_RECIP);

    // stage 1: time of day in ms
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ms1 <= 27'(i_hour) * C_MS_PER_HOUR + 27'(i_minute) * C_MS_PER_MIN
                   + 27'(i_second_ms);
        end
    end

    // stage 2: whole day carry, at most one
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_carry2 <= w_carry;
            r_msm2   <= w_carry ? (r_ms1 - C_MS_PER_DAY) : r_ms1;
        end
    end

    // stage 3: reciprocal estimate, low by at most two
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_carry3 <= r_carry2;
            r_qest3  <= w_prod[C_FRAC_SHIFT+31:C_FRAC_SHIFT];
        end
    end

    // stage 4: back-multiply, only the low bits matter for the remainder
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_carry4 <= r_carry3;
            r_qest4  <= r_qest3;
            r_prod4  <= r_qest3[C_REM_W-1:0] * C_REM_ONE;
        end
    end

    assign o_carry   = r_carry4;
    assign o_qest    = r_qest4;
    assign o_prod_lo = r_prod4;

endmodule

// File: src/cdsd_date.sv
module cdsd_date (
    input  logic                 i_clk,
    input  cdsd_pkg::t_stage_en  i_en,
    input  logic [13:0]          i_year,
    input  logic [3:0]           i_month,
    input  logic [4:0]           i_day,
    input  logic                 i_epoch_1904,
    output logic signed [cdsd_pkg::C_DAYS_W-1:0] o_days,
    output logic                 o_no_bump
);
    import cdsd_pkg::*;

    localparam logic [13:0] C_Y1899 = 14'd1899;
    localparam logic [13:0] C_Y1900 = 14'd1900;
    localparam logic [13:0] C_Y1904 = 14'd1904;
    localparam logic [3:0]  C_DEC   = 4'd12;
    localparam logic [3:0]  C_JAN   = 4'd1;
    localparam logic [3:0]  C_FEB   = 4'd2;

    // x / 100 for x below 2^15
    function automatic logic [8:0] f_div100(input logic [14:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'd5243;
        return p[27:19];
    endfunction

    // days in the months before month m, common year
    function automatic logic [8:0] f_cum(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // stage 1
    logic [3:0]  w_mon;
    logic [13:0] w_y;
    logic [3:0]  w_m;
    logic [4:0]  w_d;
    logic [13:0] r_y1;
    logic [3:0]  r_m1;
    logic [4:0]  r_d1;
    logic        r_e1, r_sp0_1, r_sp60_1;
    logic signed [15:0] r_range1, r_ro1, r_ro3_1;

    // stage 2
    logic [14:0] w_mag_r, w_mag_ro, w_mag_ro3;
    logic [8:0]  w_qy, w_q100, w_q400;
    logic [13:0] r_y2;
    logic [3:0]  r_m2;
    logic [4:0]  r_d2;
    logic        r_e2, r_sp0_2, r_sp60_2;
    logic        r_neg_r2, r_neg_ro2, r_neg_ro3_2;
    logic [12:0] r_r4_2;
    logic signed [C_DAYS_W-1:0] r_365_2;
    logic [7:0]  r_qy2;
    logic [8:0]  r_q100_2;
    logic [5:0]  r_q400_2;

    // stage 3
    logic        w_leap;
    logic signed [13:0] w_t4;
    logic signed [10:0] w_t100, w_t400;
    logic [8:0]  w_cum;
    logic        r_e3, r_sp0_3, r_sp60_3;
    logic signed [C_DAYS_W-1:0] r_sa3;
    logic signed [10:0] r_sb3, r_c3;

    // stage 4
    logic signed [C_DAYS_W-1:0] w_days;
    logic signed [C_DAYS_W-1:0] r_days4;
    logic        r_nob4;

    always_comb begin
        w_mon = (i_month > C_DEC) ? C_DEC : i_month;
        if (i_year == 14'd0) begin
            if (i_epoch_1904) begin
                w_y = C_Y1904;
                w_m = C_JAN;
                w_d = 5'd1;
            end else begin
                w_y = C_Y1899;
                w_m = C_DEC;
                w_d = 5'd31;
            end
        end else begin
            w_y = i_year;
            w_m = w_mon;
            w_d = i_day;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_y1     <= w_y;
            r_m1     <= w_m;
            r_d1     <= w_d;
            r_e1     <= i_epoch_1904;
            // base dates of the 1900 epoch
            r_sp0_1  <= !i_epoch_1904
                      && ((w_y == C_Y1899 && w_m == C_DEC && w_d == 5'd31)
                       || (w_y == C_Y1900 && w_m == C_JAN && w_d == 5'd0));
            // the false leap day
            r_sp60_1 <= !i_epoch_1904 && w_y == C_Y1900 && w_m == C_FEB && w_d == 5'd29;
            r_range1 <= $signed({2'b00, w_y}) - (i_epoch_1904 ? 16'sd1904 : 16'sd1900);
            // range plus epoch offset is year - 1900 in both epochs
            r_ro1    <= $signed({2'b00, w_y}) - 16'sd1900;
            r_ro3_1  <= $signed({2'b00, w_y}) - 16'sd1600;
        end
    end

    assign w_mag_r   = r_range1[15] ? 15'(-r_range1) : r_range1[14:0];
    assign w_mag_ro  = r_ro1[15]    ? 15'(-r_ro1)    : r_ro1[14:0];
    assign w_mag_ro3 = r_ro3_1[15]  ? 15'(-r_ro3_1)  : r_ro3_1[14:0];
    assign w_qy      = f_div100({1'b0, r_y1});
    assign w_q100    = f_div100(w_mag_ro);
    assign w_q400    = f_div100({2'b00, w_mag_ro3[14:2]});

    // quotients on magnitudes, sign put back later: division toward zero
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_y2        <= r_y1;
            r_m2        <= r_m1;
            r_d2        <= r_d1;
            r_e2        <= r_e1;
            r_sp0_2     <= r_sp0_1;
            r_sp60_2    <= r_sp60_1;
            r_neg_r2    <= r_range1[15];
            r_neg_ro2   <= r_ro1[15];
            r_neg_ro3_2 <= r_ro3_1[15];
            r_r4_2      <= w_mag_r[14:2];
            r_365_2     <= C_DAYS_W'(r_range1) * 25'sd365;
            r_qy2       <= w_qy[7:0];
            r_q100_2    <= w_q100;
            r_q400_2    <= w_q400[5:0];
        end
    end

    assign w_leap = (r_y2[1:0] == 2'b00)
                  && ((r_y2 != 14'(r_qy2) * 14'd100) || (r_qy2[1:0] == 2'b00));
    assign w_t4   = r_neg_r2    ? -$signed({1'b0, r_r4_2}) : $signed({1'b0, r_r4_2});
    assign w_t100 = r_neg_ro2   ? -$signed({2'b00, r_q100_2}) : $signed({2'b00, r_q100_2});
    assign w_t400 = r_neg_ro3_2 ? -$signed({5'b0, r_q400_2}) : $signed({5'b0, r_q400_2});
    assign w_cum  = f_cum(r_m2);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_e3     <= r_e2;
            r_sp0_3  <= r_sp0_2;
            r_sp60_3 <= r_sp60_2;
            r_sa3    <= r_365_2 + C_DAYS_W'(w_t4);
            r_sb3    <= w_t400 - w_t100;
            // the leap day is added past february and taken off once: net -1 before march
            r_c3     <= $signed({2'b00, w_cum}) + $signed({6'b0, r_d2})
                      - ((w_leap && r_m2 <= C_FEB) ? 11'sd1 : 11'sd0);
        end
    end

    assign w_days = r_sa3 + C_DAYS_W'(r_sb3) + C_DAYS_W'(r_c3);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            if (r_sp0_3) begin
                r_days4 <= '0;
            end else if (r_sp60_3) begin
                r_days4 <= 25'sd60;
            end else begin
                r_days4 <= w_days;
            end
            r_nob4 <= r_e3 || r_sp0_3 || r_sp60_3;
        end
    end

    assign o_days    = r_days4;
    assign o_no_bump = r_nob4;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // fixed numbers of the calendar and of the handshake timing
    localparam longint MS_PER_DAY   = 64'd86400000;
    localparam longint DAYS_MAX     = 64'd4194303;
    localparam bit     EPOCH_1900   = 1'b0;
    localparam bit     EPOCH_1904   = 1'b1;
    localparam int     YEAR_1899    = 1899;
    localparam int     YEAR_1900    = 1900;
    localparam int     YEAR_1903    = 1903;
    localparam int     YEAR_1904    = 1904;
    localparam int     LEAP_BUG_DAY = 59;
    localparam int     SETTLE_CYCLES = 8;    // covers the datapath stages and the output register, plus margin
    localparam int     PHASE_WORDS  = 154;
    localparam int     PRINT_LIMIT  = 40;

    // one converted date: whole days and day fraction in q0.32
    typedef struct packed {
        logic signed [22:0] days;
        logic [31:0]        frac;
    } serial_t;

    // expected serial dates, in order of acceptance
    class serial_date_board;
        bit      epoch_1904;
        serial_t awaited_serials[$];
        int      errors;

        function void set_epoch(bit value);
            epoch_1904 = value;
        endfunction

        function int month_len(int idx);
            case (idx)
                1, 3, 5, 7, 8, 10, 12: return 31;
                2:                     return 28;
                4, 6, 9, 11:           return 30;
                default:               return 0;
            endcase
        endfunction

        // date and time of day to serial date, under the current epoch
        function serial_t convert(logic [55:0] w);
            int      yr, mo, dy, span, offs, base, cnt, lp, k;
            longint  ms, carry, frac, total;
            serial_t res;
            yr = int'(w[13:0]);
            mo = int'(w[17:14]);
            dy = int'(w[22:18]);
            ms = longint'(w[27:23]) * 3600000 + longint'(w[33:28]) * 60000
                 + longint'(w[49:34]);
            carry = ms / MS_PER_DAY;
            ms    = ms % MS_PER_DAY;
            frac  = (ms << 32) / MS_PER_DAY;
            if (mo > 12)
                mo = 12;
            if (yr == 0) begin
                if (epoch_1904 == EPOCH_1900) begin
                    yr = YEAR_1899; mo = 12; dy = 31;
                end else begin
                    yr = YEAR_1904; mo = 1; dy = 1;
                end
            end
            if (epoch_1904 == EPOCH_1900 &&
                ((yr == YEAR_1899 && mo == 12 && dy == 31) ||
                 (yr == YEAR_1900 && mo == 1 && dy == 0))) begin
                total = carry;
            end else if (epoch_1904 == EPOCH_1900 && yr == YEAR_1900 && mo == 2 && dy == 29) begin
                total = 60 + carry;
            end else begin
                base = (epoch_1904 == EPOCH_1904) ? YEAR_1904 : YEAR_1900;
                offs = (epoch_1904 == EPOCH_1904) ? 4 : 0;
                span = yr - base;
                lp   = (yr % 4 == 0 && (yr % 100 > 0 || yr % 400 == 0)) ? 1 : 0;
                cnt  = 0;
                for (k = 0; k < mo; k++)
                    cnt += month_len(k) + ((k == 2) ? lp : 0);
                cnt += dy + span * 365 + span / 4 - (span + offs) / 100
                       + (span + offs + 300) / 400 - lp;
                // 1900 counted as a leap year
                if (epoch_1904 == EPOCH_1900 && cnt > LEAP_BUG_DAY)
                    cnt++;
                total = longint'(cnt) + carry;
            end
            if (total > DAYS_MAX) begin
                total = DAYS_MAX;
                frac  = 64'hFFFF_FFFF;
            end
            res.days = total[22:0];
            res.frac = frac[31:0];
            return res;
        endfunction

        function void note_date(logic [55:0] w);
            awaited_serials.push_back(convert(w));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_serial(logic [55:0] w);
            serial_t want;
            if (awaited_serials.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing awaited", w));
                return;
            end
            want = awaited_serials.pop_front();
            if (w[22:0] !== want.days)
                report_mismatch($sformatf("serial_days %0d, expected %0d",
                                          $signed(w[22:0]), want.days));
            if (w[54:23] !== want.frac)
                report_mismatch($sformatf("day_fraction %h, expected %h",
                                          w[54:23], want.frac));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] second_ms[49:34]
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // serial_days[22:0] day_fraction[54:23]
    logic [55:0] m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_wdata;

    serial_date_board board = new;

    // handshakes seen at the last rising edge, read by the drivers at the falling edge
    bit in_fire;
    bit out_fire;

    // idle percentages of the current phase
    int tx_idle_pct;
    int rx_stall_pct;

    calendar_date_to_serial_day_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sample everything at the rising edge: config writes, results, accepted words
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && i_cfg_we)
            board.set_epoch(i_cfg_wdata);
        if (out_fire)
            board.check_serial(m_axis_tdata);
        if (in_fire)
            board.note_date(s_axis_tdata);
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [55:0] pack_date(input logic [13:0] yr, input logic [3:0] mo,
                                              input logic [4:0] dy, input logic [4:0] hr,
                                              input logic [5:0] mi, input logic [15:0] ms);
        return {6'd0, ms, mi, hr, dy, mo, yr};
    endfunction

    // mostly plain dates, with time-only words, dates around the epoch bases,
    // years near saturation and raw noise mixed in
    function automatic logic [55:0] random_date();
        int          kind;
        logic [13:0] yr;
        logic [3:0]  mo;
        logic [4:0]  dy, hr;
        logic [5:0]  mi;
        logic [15:0] ms;
        kind = $urandom_range(99);
        yr = 14'($urandom_range(9999, 1));
        mo = 4'($urandom_range(12, 1));
        dy = 5'($urandom_range(31, 1));
        hr = 5'($urandom_range(23, 0));
        mi = 6'($urandom_range(59, 0));
        ms = 16'($urandom_range(59999, 0));
        if (kind < 10) begin
            yr = 14'($urandom_range(16383, 0));
            mo = 4'($urandom_range(15, 0));
            dy = 5'($urandom_range(31, 0));
        end else if (kind < 18) begin
            // time only, date fields are don't-care
            yr = 0;
            mo = 4'($urandom_range(15, 0));
            dy = 5'($urandom_range(31, 0));
        end else if (kind < 30) begin
            case ($urandom_range(3))
                0:       yr = 14'(YEAR_1899);
                1:       yr = 14'(YEAR_1900);
                2:       yr = 14'(YEAR_1903);
                default: yr = 14'(YEAR_1904);
            endcase
            mo = 4'($urandom_range(15, 0));
            dy = 5'($urandom_range(31, 0));
        end else if (kind < 38) begin
            // saturation sets in around year 13380
            yr = $urandom_range(1) ? 14'($urandom_range(13600, 13200))
                                   : 14'($urandom_range(16383, 10000));
        end
        if (kind < 10 || $urandom_range(9) == 0) begin
            // time fields over their full width, may carry into the next day
            hr = 5'($urandom_range(31, 0));
            mi = 6'($urandom_range(63, 0));
            ms = 16'($urandom_range(65535, 0));
        end
        return pack_date(yr, mo, dy, hr, mi, ms);
    endfunction

    // one word on s_axis, with random idle cycles ahead of it; returns at the
    // falling edge after acceptance, tvalid still high
    task automatic send_date(input logic [55:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = word;
        s_axis_tvalid = 1'b1;
        do @(negedge i_clk); while (!in_fire);
    endtask

    // hold off the sender until every awaited result is back
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (board.awaited_serials.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // epoch bit written only with the pipe empty
    task automatic write_epoch(input bit value);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        int ph, n, mode;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        board.set_epoch(EPOCH_1900);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words, 1900 epoch straight out of reset
        send_date(pack_date(0, 0, 0, 0, 0, 0));              // time only, midnight
        send_date(pack_date(0, 15, 31, 31, 63, 65535));      // time only, carry past a day
        send_date(pack_date(1899, 12, 31, 12, 0, 0));        // base date
        send_date(pack_date(1900, 1, 0, 6, 30, 1500));       // january zero
        send_date(pack_date(1900, 2, 29, 0, 0, 0));          // false leap day
        send_date(pack_date(1900, 2, 28, 23, 59, 59999));    // last day before the bug
        send_date(pack_date(1900, 3, 1, 0, 0, 0));           // first day after the bug
        send_date(pack_date(1900, 1, 1, 0, 0, 1));
        send_date(pack_date(2000, 15, 31, 8, 0, 0));         // month clamped to december
        send_date(pack_date(9999, 12, 31, 23, 59, 59999));   // top of the legal range
        send_date(pack_date(16383, 15, 31, 31, 63, 65535));  // saturates
        send_date(pack_date(1, 0, 0, 0, 0, 0));              // far before the epoch
        send_date(pack_date(2000, 2, 29, 12, 0, 0));         // leap by the 400 rule
        send_date(pack_date(2100, 3, 1, 0, 0, 0));           // no leap by the 100 rule
        send_date(pack_date(2023, 2, 31, 0, 0, 0));          // day past the month end
        send_date(pack_date(2023, 7, 4, 24, 0, 0));          // exactly one day of time
        send_date(pack_date(1899, 12, 30, 0, 0, 0));         // one day before the base

        // directed words, 1904 epoch
        write_epoch(EPOCH_1904);
        send_date(pack_date(0, 7, 9, 18, 45, 30000));        // time only
        send_date(pack_date(1904, 1, 1, 0, 0, 0));
        send_date(pack_date(1904, 1, 0, 0, 0, 0));
        send_date(pack_date(1900, 2, 29, 0, 0, 0));          // no special meaning here
        send_date(pack_date(1, 1, 1, 0, 0, 0));
        send_date(pack_date(16383, 15, 31, 31, 63, 65535));
        send_date(pack_date(1903, 12, 31, 23, 59, 59999));

        // random phases: no idling, sender idle, receiver stalling, both;
        // each under both epochs, with one full drain halfway through
        for (ph = 0; ph < 8; ph++) begin
            write_epoch(ph[0] ? EPOCH_1904 : EPOCH_1900);
            mode = ph / 2;
            tx_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 14 : 0;
            rx_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 14 : 0;
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2)
                    drain_results();
                send_date(random_date());
            end
        end

        drain_results();
        if (board.errors == 0 && board.awaited_serials.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
